// File: rtl/core/apu_pkg.sv
// ============================================================================
// apu_pkg
// Shared constants and types for the Adam parameter update unit.
// ============================================================================
package apu_pkg;

    localparam int PARAM_COUNT = 32;
    localparam int ADDR_W      = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

    localparam int IDX_W      = 5;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam int M_W   = 32;
    localparam int V_W   = 48;
    localparam int MOM_W = M_W + V_W;

    typedef logic [MOM_W-1:0] moment_t;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_ONE      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_TWO      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 4'd3;

    localparam logic [23:0] LR_RESET  = 24'd167772;
    localparam logic [23:0] B1_RESET  = 24'd15099494;
    localparam logic [23:0] B2_RESET  = 24'd16760439;
    localparam logic [15:0] EPS_RESET = 16'd1;

endpackage

// File: rtl/core/adam_parameter_update_unit.sv
// ============================================================================
// adam_parameter_update_unit
// Adam optimizer update engine, fixed point, one shared iterative datapath.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) takes one request: param_index,
//   gradient (Q8.24), current_param (Q8.24) and step_start. step_start
//   advances both beta powers before the moments are updated.
//   Output channel (out_valid/out_ready) returns new_param and result_index,
//   exactly one result per request, in order.
//   Config channel (cfg_valid/cfg_ready) writes learning_rate, beta_one,
//   beta_two, epsilon by index; cfg_ready is always high. Write only when idle.
// Timing:
//   One request at a time; after each result the unit returns to idle before
//   it takes the next request. Each request runs three bit-serial divisions
//   (88, 104, 88 steps), a 32-step square root and up to eight shift-add
//   multiplies (one multiplier bit per cycle, stopping early when the remaining
//   bits are zero). The single shared divider and multiplier set the latency.
// Reset:
//   Config returns to defaults, beta powers to one, and a clearing pass over
//   all PARAM_COUNT (32) entries zeroes the moment RAM; in_ready stays low meanwhile.
// Stall:
//   A finished result sits in the output register; the next request is still
//   accepted, but it cannot retire until the previous result is taken.
// ============================================================================
module adam_parameter_update_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // config
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [apu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [apu_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [apu_pkg::IDX_W-1:0]        param_index,
    input  logic signed [apu_pkg::DATA_W-1:0] gradient,
    input  logic signed [apu_pkg::DATA_W-1:0] current_param,
    input  logic                             step_start,
    // result
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [apu_pkg::DATA_W-1:0] new_param,
    output logic [apu_pkg::IDX_W-1:0]        result_index
);

    import apu_pkg::*;

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_BP1   = 4'd3;
    localparam logic [3:0] ST_BP2   = 4'd4;
    localparam logic [3:0] ST_M1    = 4'd5;
    localparam logic [3:0] ST_M2    = 4'd6;
    localparam logic [3:0] ST_V1    = 4'd7;
    localparam logic [3:0] ST_V2    = 4'd8;
    localparam logic [3:0] ST_V3    = 4'd9;
    localparam logic [3:0] ST_D1    = 4'd10;
    localparam logic [3:0] ST_D2    = 4'd11;
    localparam logic [3:0] ST_SQ    = 4'd12;
    localparam logic [3:0] ST_LR    = 4'd13;
    localparam logic [3:0] ST_D3    = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [3:0]        st_reg, st_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]       grad_reg, grad_next;
    logic [31:0]       cur_reg, cur_next;
    logic              ss_reg, ss_next;

    logic [24:0]       bp1_reg, bp1_next;
    logic [24:0]       bp2_reg, bp2_next;

    logic [23:0]       lr_reg, b1_reg, b2_reg;
    logic [15:0]       eps_reg;

    logic [31:0]       mnew_reg, mnew_next;
    logic [47:0]       vnew_reg, vnew_next;
    logic [63:0]       tmp_reg, tmp_next;

    // shift-add multiplier
    logic [95:0]       acc_reg, acc_next;
    logic [95:0]       mcand_reg, mcand_next;
    logic [31:0]       mplier_reg, mplier_next;

    // restoring divider
    logic [63:0]       dvd_reg, dvd_next;
    logic [33:0]       rem_reg, rem_next;
    logic [63:0]       quo_reg, quo_next;
    logic              sat_reg, sat_next;
    logic [32:0]       den_reg, den_next;
    logic [6:0]        cnt_reg, cnt_next;

    // digit-by-digit square root
    logic [63:0]       sx_reg, sx_next;
    logic [63:0]       res_reg, res_next;
    logic [63:0]       bit_reg, bit_next;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       np_reg, np_next;
    logic [IDX_W-1:0]  ri_reg, ri_next;

    // ------------------------------------------------------------------
    // moment RAM: {first moment, second moment}
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    moment_t           ram_wdata, ram_rdata;

    apu_ram #(
        .WIDTH (MOM_W),
        .DEPTH (PARAM_COUNT)
    ) u_mom_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    logic [31:0] m_old, mmag_old, gmag, mmag_new;
    logic [47:0] v_old;
    logic        in_range;
    logic [24:0] d1, d2, d1e, d2e;
    logic [15:0] eps_eff;

    logic [95:0] acc_step;
    logic [33:0] r_sh, r_sub;
    logic        r_ge;
    logic [63:0] div_q;
    logic [63:0] s_sum;
    logic        s_ge;

    logic [63:0] msum;
    logic [56:0] vsum;
    logic [47:0] vsat;
    logic [33:0] dcl;
    logic [34:0] p35, d35, r35;
    logic [31:0] rsat;

    assign m_old    = ram_rdata[MOM_W-1:V_W];
    assign v_old    = ram_rdata[V_W-1:0];
    assign mmag_old = m_old[31] ? (~m_old + 32'd1) : m_old;
    assign gmag     = grad_reg[31] ? (~grad_reg + 32'd1) : grad_reg;
    assign mmag_new = mnew_reg[31] ? (~mnew_reg + 32'd1) : mnew_reg;
    assign in_range = (32'(idx_reg) < PARAM_COUNT);

    // bias-correction divisors; one LSB before the first step
    assign d1      = ONE_Q24 - bp1_reg;
    assign d2      = ONE_Q24 - bp2_reg;
    assign d1e     = (d1 == 25'd0) ? 25'd1 : d1;
    assign d2e     = (d2 == 25'd0) ? 25'd1 : d2;
    assign eps_eff = (eps_reg == 16'd0) ? 16'd1 : eps_reg;

    assign acc_step = acc_reg + (mplier_reg[0] ? mcand_reg : 96'd0);

    assign r_sh  = {rem_reg[32:0], dvd_reg[63]};
    assign r_ge  = (r_sh >= {1'b0, den_reg});
    assign r_sub = r_sh - {1'b0, den_reg};
    assign div_q = sat_reg ? {64{1'b1}} : quo_reg;

    assign s_sum = res_reg + bit_reg;
    assign s_ge  = (sx_reg >= s_sum);

    assign msum = tmp_reg + (grad_reg[31] ? (~acc_reg[63:0] + 64'd1) : acc_reg[63:0]);
    assign vsum = {9'd0, tmp_reg[47:0]} + {1'b0, acc_reg[95:40]};
    assign vsat = (|vsum[56:48]) ? {48{1'b1}} : vsum[47:0];

    // final step: delta limited to 2^33, then saturate to int32
    assign dcl  = (div_q > 64'h2_0000_0000) ? 34'h2_0000_0000 : div_q[33:0];
    assign p35  = {{3{cur_reg[31]}}, cur_reg};
    assign d35  = {1'b0, tmp_reg[33:0]};
    assign r35  = mnew_reg[31] ? (p35 + d35) : (p35 - d35);
    assign rsat = (r35[34:31] == 4'b0000 || r35[34:31] == 4'b1111) ? r35[31:0]
                : (r35[34] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        st_next        = st_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        grad_next      = grad_reg;
        cur_next       = cur_reg;
        ss_next        = ss_reg;
        bp1_next       = bp1_reg;
        bp2_next       = bp2_reg;
        mnew_next      = mnew_reg;
        vnew_next      = vnew_reg;
        tmp_next       = tmp_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        sat_next       = sat_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        sx_next        = sx_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        np_next        = np_reg;
        ri_next        = ri_reg;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(idx_reg);
        ram_wdata      = {mnew_reg, vsat};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // iteration of whichever shared unit is running
        if (st_reg == ST_BP1 || st_reg == ST_BP2 || st_reg == ST_M1 || st_reg == ST_M2
            || st_reg == ST_V1 || st_reg == ST_V2 || st_reg == ST_V3 || st_reg == ST_LR)
        begin
            if (mplier_reg != 32'd0)
            begin
                acc_next    = acc_step;
                mcand_next  = {mcand_reg[94:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[31:1]};
            end
        end
        if (st_reg == ST_D1 || st_reg == ST_D2 || st_reg == ST_D3)
        begin
            if (cnt_reg != 7'd0)
            begin
                dvd_next = {dvd_reg[62:0], 1'b0};
                rem_next = r_ge ? r_sub : r_sh;
                quo_next = {quo_reg[62:0], r_ge};
                sat_next = sat_reg | quo_reg[63];
                cnt_next = cnt_reg - 7'd1;
            end
        end
        if (st_reg == ST_SQ && bit_reg != 64'd0)
        begin
            if (s_ge)
            begin
                sx_next  = sx_reg - s_sum;
                res_next = {1'b0, res_reg[63:1]} + bit_reg;
            end
            else
            begin
                res_next = {1'b0, res_reg[63:1]};
            end
            bit_next = {2'b00, bit_reg[63:2]};
        end

        unique case (st_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (32'(clr_reg) == PARAM_COUNT - 1)
                begin
                    st_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next  = param_index;
                    grad_next = gradient;
                    cur_next  = current_param;
                    ss_next   = step_start;
                    st_next   = ST_RD;
                end
            end
            ST_RD:
            begin
                acc_next = '0;
                if (ss_reg)
                begin
                    mcand_next  = 96'(bp1_reg);
                    mplier_next = 32'(b1_reg);
                    st_next     = ST_BP1;
                end
                else if (in_range)
                begin
                    mcand_next  = 96'(mmag_old);
                    mplier_next = 32'(b1_reg);
                    st_next     = ST_M1;
                end
                else
                begin
                    tmp_next = '0;
                    st_next  = ST_OUT;
                end
            end
            ST_BP1:
            begin
                if (mplier_reg == 32'd0)
                begin
                    bp1_next    = acc_reg[48:24];
                    acc_next    = '0;
                    mcand_next  = 96'(bp2_reg);
                    mplier_next = 32'(b2_reg);
                    st_next     = ST_BP2;
                end
            end
            ST_BP2:
            begin
                if (mplier_reg == 32'd0)
                begin
                    bp2_next = acc_reg[48:24];
                    acc_next = '0;
                    if (in_range)
                    begin
                        mcand_next  = 96'(mmag_old);
                        mplier_next = 32'(b1_reg);
                        st_next     = ST_M1;
                    end
                    else
                    begin
                        tmp_next = '0;
                        st_next  = ST_OUT;
                    end
                end
            end
            ST_M1:
            begin
                if (mplier_reg == 32'd0)
                begin
                    tmp_next    = m_old[31] ? (~acc_reg[63:0] + 64'd1) : acc_reg[63:0];
                    acc_next    = '0;
                    mcand_next  = 96'(gmag);
                    mplier_next = 32'(ONE_Q24 - {1'b0, b1_reg});
                    st_next     = ST_M2;
                end
            end
            ST_M2:
            begin
                if (mplier_reg == 32'd0)
                begin
                    // arithmetic shift by 24 is the floor
                    mnew_next   = msum[55:24];
                    acc_next    = '0;
                    mcand_next  = 96'(v_old);
                    mplier_next = 32'(b2_reg);
                    st_next     = ST_V1;
                end
            end
            ST_V1:
            begin
                if (mplier_reg == 32'd0)
                begin
                    tmp_next    = 64'(acc_reg[71:24]);
                    acc_next    = '0;
                    mcand_next  = 96'(gmag);
                    mplier_next = gmag;
                    st_next     = ST_V2;
                end
            end
            ST_V2:
            begin
                if (mplier_reg == 32'd0)
                begin
                    acc_next    = '0;
                    mcand_next  = 96'(acc_reg[63:0]);
                    mplier_next = 32'(ONE_Q24 - {1'b0, b2_reg});
                    st_next     = ST_V3;
                end
            end
            ST_V3:
            begin
                if (mplier_reg == 32'd0)
                begin
                    vnew_next = vsat;
                    ram_we    = 1'b1;
                    // mh = |m| * 2^24 / d1
                    dvd_next  = 64'(mmag_new);
                    rem_next  = '0;
                    quo_next  = '0;
                    sat_next  = 1'b0;
                    den_next  = 33'(d1e);
                    cnt_next  = 7'd88;
                    st_next   = ST_D1;
                end
            end
            ST_D1:
            begin
                if (cnt_reg == 7'd0)
                begin
                    tmp_next = div_q;
                    dvd_next = 64'(vnew_reg);
                    rem_next = '0;
                    quo_next = '0;
                    sat_next = 1'b0;
                    den_next = 33'(d2e);
                    cnt_next = 7'd104;
                    st_next  = ST_D2;
                end
            end
            ST_D2:
            begin
                if (cnt_reg == 7'd0)
                begin
                    sx_next  = div_q;
                    res_next = '0;
                    bit_next = 64'h4000_0000_0000_0000;
                    st_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (bit_reg == 64'd0)
                begin
                    den_next    = res_reg[32:0] + 33'(eps_eff);
                    acc_next    = '0;
                    mcand_next  = 96'(tmp_reg);
                    mplier_next = 32'(lr_reg);
                    st_next     = ST_LR;
                end
            end
            ST_LR:
            begin
                if (mplier_reg == 32'd0)
                begin
                    dvd_next = acc_reg[87:24];
                    rem_next = '0;
                    quo_next = '0;
                    sat_next = 1'b0;
                    cnt_next = 7'd88;
                    st_next  = ST_D3;
                end
            end
            ST_D3:
            begin
                if (cnt_reg == 7'd0)
                begin
                    tmp_next = 64'(dcl);
                    st_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    np_next        = rsat;
                    ri_next        = idx_reg;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign ram_raddr = (st_reg == ST_IDLE) ? ADDR_W'(param_index) : ADDR_W'(idx_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            clr_reg       <= '0;
            bp1_reg       <= ONE_Q24;
            bp2_reg       <= ONE_Q24;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            bp1_reg       <= bp1_next;
            bp2_reg       <= bp2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RESET;
            b1_reg  <= B1_RESET;
            b2_reg  <= B2_RESET;
            eps_reg <= EPS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE: lr_reg  <= cfg_data;
                CFG_BETA_ONE:      b1_reg  <= cfg_data;
                CFG_BETA_TWO:      b2_reg  <= cfg_data;
                CFG_EPSILON:       eps_reg <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        grad_reg   <= grad_next;
        cur_reg    <= cur_next;
        ss_reg     <= ss_next;
        mnew_reg   <= mnew_next;
        vnew_reg   <= vnew_next;
        tmp_reg    <= tmp_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        sat_reg    <= sat_next;
        den_reg    <= den_next;
        cnt_reg    <= cnt_next;
        sx_reg     <= sx_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        np_reg     <= np_next;
        ri_reg     <= ri_next;
    end

    assign cfg_ready    = 1'b1;
    assign in_ready     = (st_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign new_param    = np_reg;
    assign result_index = ri_reg;

`ifndef SYNTH
    // an accepted request always starts with the moment read
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> st_reg == ST_RD)
        else $error("request accepted without entering read");

    // a pending result is never dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // restoring divider keeps partial remainder below divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_D1 || st_reg == ST_D2 || st_reg == ST_D3)
        |-> rem_reg < {1'b0, den_reg})
        else $error("divider remainder out of range");

    // beta powers never exceed one
    a_bp_range: assert property (@(posedge clk) disable iff (!rst_n)
        bp1_reg <= ONE_Q24 && bp2_reg <= ONE_Q24)
        else $error("beta power above one");
`endif

endmodule

// File: rtl/core/apu_ram.sv
// ============================================================================
// apu_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module apu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
